// ===== hw/rtl/rsfm_pkg.sv =====
// ----------------------------------------------------------------------------
// rsfm_pkg
// Shared constants, types and byte helpers for the ranked substring and
// fuzzy matcher.
// ----------------------------------------------------------------------------
package rsfm_pkg;

  localparam int QUERY_MAX_DEF   = 16;
  localparam int TEXT_MAX_DEF    = 65536;
  localparam int QUERY_REG_BYTES = 16;
  localparam int BYTE_W          = 8;
  localparam int LEN_W           = 5;
  localparam int CFG_DATA_W      = 64;
  localparam int CFG_IDX_W       = 2;
  localparam int POS_OUT_W       = 16;
  localparam int RANK_W          = 2;
  localparam int SCORE_W         = 24;
  localparam int OUT_DATA_W      = 48;

  localparam int SCORE_BASE  = 100000;
  localparam int BONUS_START = 20000;
  localparam int BONUS_WHOLE = 40000;
  localparam int BONUS_FUZZY = 50000;
  localparam int SPAN_WEIGHT = 100;

  localparam logic [RANK_W-1:0] RANK_NONE  = 2'd0;
  localparam logic [RANK_W-1:0] RANK_START = 2'd1;
  localparam logic [RANK_W-1:0] RANK_WHOLE = 2'd3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_QUERY_LOW,
    CFG_QUERY_HIGH,
    CFG_QUERY_LEN,
    CFG_MODE
  } cfg_reg_t;

  typedef enum logic {
    MODE_EXACT,
    MODE_FUZZY
  } mode_t;

  typedef struct packed {
    logic              hit;
    logic [RANK_W-1:0] rank;
  } cand_t;

  function automatic logic [BYTE_W-1:0] fold(input logic [BYTE_W-1:0] b);
    logic [BYTE_W-1:0] r;
    r = b;
    if (b >= 8'h41 && b <= 8'h5A) begin
      r = b + 8'd32;
    end
    return r;
  endfunction

  // word bytes: digits, letters, underscore
  function automatic logic is_word(input logic [BYTE_W-1:0] b);
    return (b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h5A) ||
           (b >= 8'h61 && b <= 8'h7A) || (b == 8'h5F);
  endfunction

endpackage

// ===== hw/rtl/rsfm_cand.sv =====
// ----------------------------------------------------------------------------
// rsfm_cand
// Checks one candidate occurrence in the byte window against the query and
// ranks it by its word boundaries.
// ----------------------------------------------------------------------------
module rsfm_cand #(
  parameter int QLEN_MAX = 16,
  parameter int NW       = 5
) (
  input  logic [rsfm_pkg::BYTE_W-1:0] win [QLEN_MAX+1],
  input  logic [rsfm_pkg::BYTE_W-1:0] qf  [QLEN_MAX],
  input  logic [NW-1:0]               n,
  input  logic                        valid,
  input  logic                        start_zero,
  input  logic                        tail_clear,
  output rsfm_pkg::cand_t             cand
);

  logic mismatch;
  logic head_clear;

  // window slot j (newest first) holds query byte n-1-j
  always_comb begin
    mismatch = 1'b0;
    for (int j = 0; j < QLEN_MAX; j++) begin
      for (int i = 0; i < QLEN_MAX; i++) begin
        if (j < int'(n) && (i + j + 1) == int'(n) && win[j] != qf[i]) begin
          mismatch = 1'b1;
        end
      end
    end
  end

  assign head_clear = start_zero || !rsfm_pkg::is_word(win[n]);

  always_comb begin
    cand.hit = valid && !mismatch;
    if (head_clear && tail_clear) begin
      cand.rank = rsfm_pkg::RANK_WHOLE;
    end else if (head_clear) begin
      cand.rank = rsfm_pkg::RANK_START;
    end else begin
      cand.rank = rsfm_pkg::RANK_NONE;
    end
  end

endmodule

// ===== hw/rtl/rsfm_score.sv =====
// ----------------------------------------------------------------------------
// rsfm_score
// Forms the result fields of one haystack from the final match state under
// the exact or fuzzy scoring formula.
// ----------------------------------------------------------------------------
module rsfm_score #(
  parameter int PW = 16
) (
  input  rsfm_pkg::mode_t                    mode,
  input  logic                               len_nz,
  input  logic                               best_found,
  input  logic [PW-1:0]                      best_pos,
  input  logic [rsfm_pkg::RANK_W-1:0]        best_rank,
  input  logic                               sub_done,
  input  logic [PW-1:0]                      sub_first,
  input  logic [PW-1:0]                      sub_last,
  output logic                               found,
  output logic [rsfm_pkg::POS_OUT_W-1:0]     position,
  output logic [rsfm_pkg::RANK_W-1:0]        rank,
  output logic [rsfm_pkg::SCORE_W-1:0]       score
);

  localparam int SW = rsfm_pkg::SCORE_W;

  logic [SW-1:0] bonus;
  logic [SW-1:0] best_pos_w;
  logic [SW-1:0] capped;
  logic [PW:0]   span;
  logic [SW-1:0] span_w;
  logic [SW-1:0] first_w;
  logic [SW-1:0] exact_score;
  logic [SW-1:0] fuzzy_score;
  logic [SW-1:0] pos_w;

  always_comb begin
    bonus = '0;
    if (best_rank >= rsfm_pkg::RANK_START) begin
      bonus = bonus + SW'(rsfm_pkg::BONUS_START);
    end
    if (best_rank >= 2'd2) begin
      bonus = bonus + SW'(rsfm_pkg::BONUS_WHOLE);
    end
  end

  assign best_pos_w = SW'(best_pos);
  assign capped     = (best_pos_w > SW'(rsfm_pkg::SCORE_BASE)) ?
                      SW'(rsfm_pkg::SCORE_BASE) : best_pos_w;
  assign exact_score = SW'(rsfm_pkg::SCORE_BASE) - capped + bonus;

  assign span    = (sub_last >= sub_first) ?
                   ({1'b0, sub_last} - {1'b0, sub_first} + (PW+1)'(1)) : '0;
  assign span_w  = SW'(span);
  assign first_w = SW'(sub_first);

  // score wraps to the field width, so modular arithmetic is exact
  always_comb begin
    fuzzy_score = SW'(rsfm_pkg::SCORE_BASE) - span_w * SW'(rsfm_pkg::SPAN_WEIGHT)
                  - first_w;
    if (best_found) begin
      fuzzy_score = fuzzy_score + SW'(rsfm_pkg::BONUS_FUZZY) + bonus;
    end
  end

  always_comb begin
    found = 1'b0;
    pos_w = '0;
    rank  = rsfm_pkg::RANK_NONE;
    score = '0;
    if (len_nz) begin
      case (mode)
        rsfm_pkg::MODE_EXACT: begin
          if (best_found) begin
            found = 1'b1;
            pos_w = best_pos_w;
            rank  = best_rank;
            score = exact_score;
          end
        end
        rsfm_pkg::MODE_FUZZY: begin
          if (sub_done) begin
            found = 1'b1;
            score = fuzzy_score;
            if (best_found) begin
              pos_w = best_pos_w;
              rank  = best_rank;
            end else begin
              pos_w = first_w;
            end
          end
        end
        default: begin
          found = 1'b0;
        end
      endcase
    end
  end

  assign position = pos_w[rsfm_pkg::POS_OUT_W-1:0];

endmodule

// ===== hw/rtl/ranked_substring_and_fuzzy_matcher.sv =====
// ----------------------------------------------------------------------------
// ranked_substring_and_fuzzy_matcher
// Streams haystack bytes against a configured query and reports the best
// ranked contiguous hit and a greedy subsequence score per haystack.
// ----------------------------------------------------------------------------
// Usage: load the query through cfg_we/cfg_index/cfg_data while idle, then
// stream haystack bytes on the s_ channel, one byte per beat, with s_tlast on
// the final byte. Every s_ beat is compared case-insensitively in a single
// registered step: the byte is captured in an input register, from which the
// window, best hit and subsequence state are then updated. Throughput: one
// byte per cycle, as the window compare and best-hit update run on each byte,
// while no final byte waits on a pending result. A haystack's result appears
// on m_tvalid once its last beat is processed; no other beat yields a result.
// Bytes beyond TEXT_MAX are dropped and flag overflowed in the result.
// Stall: a pending result is held in the output register while m_tready is
// low; non-final bytes keep flowing, and a final byte waits in the input
// register, which then drops s_tready until the result is taken.
// Reset (rst, synchronous) clears the query registers, the run state but for
// the byte window, and both valid flags; after each result the run state
// returns to its reset value while the query registers are kept.
// ----------------------------------------------------------------------------
module ranked_substring_and_fuzzy_matcher #(
  parameter int QUERY_MAX = rsfm_pkg::QUERY_MAX_DEF,
  parameter int TEXT_MAX  = rsfm_pkg::TEXT_MAX_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [rsfm_pkg::BYTE_W-1:0]         s_tdata,   // [7:0] text_byte
  input  logic                                s_tlast,   // end_of_text
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // [0] found, [16:1] hit position, [18:17] hit rank,
  // [42:19] match_score, [43] overflowed, [47:44] zero
  output logic [rsfm_pkg::OUT_DATA_W-1:0]     m_tdata,
  input  logic                                cfg_we,
  input  logic [rsfm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [rsfm_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int QLEN_MAX = (QUERY_MAX < rsfm_pkg::QUERY_REG_BYTES) ?
                            QUERY_MAX : rsfm_pkg::QUERY_REG_BYTES;
  localparam int NW = $clog2(QLEN_MAX + 1);
  localparam int CW = $clog2(TEXT_MAX + 1);
  localparam int PW = $clog2(TEXT_MAX);
  localparam int BW = rsfm_pkg::BYTE_W;
  localparam int RW = rsfm_pkg::RANK_W;

  // configuration registers
  logic [rsfm_pkg::CFG_DATA_W-1:0] query_low;
  logic [rsfm_pkg::CFG_DATA_W-1:0] query_high;
  logic [rsfm_pkg::LEN_W-1:0]      query_length;
  rsfm_pkg::mode_t                 search_mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      query_low    <= '0;
      query_high   <= '0;
      query_length <= '0;
      search_mode  <= rsfm_pkg::MODE_EXACT;
    end else if (cfg_we) begin
      case (rsfm_pkg::cfg_reg_t'(cfg_index))
        rsfm_pkg::CFG_QUERY_LOW:  query_low    <= cfg_data;
        rsfm_pkg::CFG_QUERY_HIGH: query_high   <= cfg_data;
        rsfm_pkg::CFG_QUERY_LEN:  query_length <= cfg_data[rsfm_pkg::LEN_W-1:0];
        rsfm_pkg::CFG_MODE:       search_mode  <= rsfm_pkg::mode_t'(cfg_data[0]);
        default: begin
          query_low <= query_low;
        end
      endcase
    end
  end

  logic [BW-1:0]                          qf [QLEN_MAX];
  logic [2*rsfm_pkg::CFG_DATA_W-1:0]      query_all;
  logic [NW-1:0]                          n;
  logic                                   n_nz;

  assign query_all = {query_high, query_low};

  always_comb begin
    for (int i = 0; i < QLEN_MAX; i++) begin
      qf[i] = rsfm_pkg::fold(query_all[BW*i +: BW]);
    end
  end

  assign n    = (int'(query_length) > QLEN_MAX) ? NW'(QLEN_MAX) : NW'(query_length);
  assign n_nz = (n != '0);

  // input register
  logic          in_valid;
  logic [BW-1:0] in_byte;
  logic          in_last;
  logic          process;

  assign process  = in_valid && (!in_last || !m_tvalid || m_tready);
  assign s_tready = !in_valid || process;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= rsfm_pkg::fold(s_tdata);
      in_last <= s_tlast;
    end
  end

  // run state
  logic [BW-1:0] win [QLEN_MAX+1];
  logic [CW-1:0] byte_pos;
  logic          best_found;
  logic [PW-1:0] best_pos;
  logic [RW-1:0] best_rank;
  logic [NW-1:0] sub_idx;
  logic [PW-1:0] sub_first;
  logic [PW-1:0] sub_last;
  logic          ovf;

  logic          take;
  logic [BW-1:0] win_shift [QLEN_MAX+1];
  logic [BW-1:0] win_b     [QLEN_MAX+1];
  logic [CW-1:0] byte_pos_next;
  logic [PW-1:0] pos_now;
  logic [PW-1:0] s_a;
  logic [PW-1:0] s_b;
  logic          valid_a;
  logic          valid_b;
  rsfm_pkg::cand_t cand_a;
  rsfm_pkg::cand_t cand_b;

  assign take    = (byte_pos < CW'(TEXT_MAX));
  assign pos_now = byte_pos[PW-1:0];

  always_comb begin
    win_shift[0] = in_byte;
    for (int j = 1; j <= QLEN_MAX; j++) begin
      win_shift[j] = win[j-1];
    end
    for (int j = 0; j <= QLEN_MAX; j++) begin
      win_b[j] = take ? win_shift[j] : win[j];
    end
  end

  assign byte_pos_next = take ? (byte_pos + CW'(1)) : byte_pos;

  // candidate ending at the previous byte, closed by this one
  assign valid_a = take && n_nz && (byte_pos >= CW'(n));
  assign s_a     = PW'(byte_pos - CW'(n));

  // candidate ending at the last accepted byte of the haystack
  assign valid_b = in_last && n_nz && (byte_pos_next >= CW'(n));
  assign s_b     = PW'(byte_pos_next - CW'(n));

  rsfm_cand #(
    .QLEN_MAX (QLEN_MAX),
    .NW       (NW)
  ) u_cand_prev (
    .win        (win),
    .qf         (qf),
    .n          (n),
    .valid      (valid_a),
    .start_zero (byte_pos == CW'(n)),
    .tail_clear (!rsfm_pkg::is_word(in_byte)),
    .cand       (cand_a)
  );

  rsfm_cand #(
    .QLEN_MAX (QLEN_MAX),
    .NW       (NW)
  ) u_cand_end (
    .win        (win_b),
    .qf         (qf),
    .n          (n),
    .valid      (valid_b),
    .start_zero (byte_pos_next == CW'(n)),
    .tail_clear (1'b1),
    .cand       (cand_b)
  );

  logic          found_a;
  logic [PW-1:0] pos_a;
  logic [RW-1:0] rank_a;
  logic          best_found_next;
  logic [PW-1:0] best_pos_next;
  logic [RW-1:0] best_rank_next;

  // better rank wins, earlier position on a tie
  always_comb begin
    found_a = best_found;
    pos_a   = best_pos;
    rank_a  = best_rank;
    if (cand_a.hit && (!best_found || cand_a.rank > best_rank ||
        (cand_a.rank == best_rank && s_a < best_pos))) begin
      found_a = 1'b1;
      pos_a   = s_a;
      rank_a  = cand_a.rank;
    end
    best_found_next = found_a;
    best_pos_next   = pos_a;
    best_rank_next  = rank_a;
    if (cand_b.hit && (!found_a || cand_b.rank > rank_a ||
        (cand_b.rank == rank_a && s_b < pos_a))) begin
      best_found_next = 1'b1;
      best_pos_next   = s_b;
      best_rank_next  = cand_b.rank;
    end
  end

  logic [BW-1:0] sub_q;
  logic          sub_hit;
  logic [NW-1:0] sub_idx_next;
  logic [PW-1:0] sub_first_next;
  logic [PW-1:0] sub_last_next;

  always_comb begin
    sub_q = '0;
    for (int i = 0; i < QLEN_MAX; i++) begin
      if (int'(sub_idx) == i) begin
        sub_q = qf[i];
      end
    end
  end

  assign sub_hit = take && n_nz && (sub_idx < n) && (in_byte == sub_q);

  always_comb begin
    sub_idx_next   = sub_idx;
    sub_first_next = sub_first;
    sub_last_next  = sub_last;
    if (sub_hit) begin
      if (sub_idx == '0) begin
        sub_first_next = pos_now;
      end
      sub_last_next = pos_now;
      sub_idx_next  = sub_idx + NW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (process && take) begin
      for (int j = 0; j <= QLEN_MAX; j++) begin
        win[j] <= win_shift[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_pos   <= '0;
      best_found <= 1'b0;
      best_pos   <= '0;
      best_rank  <= rsfm_pkg::RANK_NONE;
      sub_idx    <= '0;
      sub_first  <= '0;
      sub_last   <= '0;
      ovf        <= 1'b0;
    end else if (process) begin
      if (in_last) begin
        byte_pos   <= '0;
        best_found <= 1'b0;
        best_pos   <= '0;
        best_rank  <= rsfm_pkg::RANK_NONE;
        sub_idx    <= '0;
        sub_first  <= '0;
        sub_last   <= '0;
        ovf        <= 1'b0;
      end else begin
        byte_pos   <= byte_pos_next;
        best_found <= best_found_next;
        best_pos   <= best_pos_next;
        best_rank  <= best_rank_next;
        sub_idx    <= sub_idx_next;
        sub_first  <= sub_first_next;
        sub_last   <= sub_last_next;
        ovf        <= ovf | !take;
      end
    end
  end

  // result
  logic                               res_found;
  logic [rsfm_pkg::POS_OUT_W-1:0]     res_pos;
  logic [RW-1:0]                      res_rank;
  logic [rsfm_pkg::SCORE_W-1:0]       res_score;

  rsfm_score #(
    .PW (PW)
  ) u_score (
    .mode       (search_mode),
    .len_nz     (n_nz),
    .best_found (best_found_next),
    .best_pos   (best_pos_next),
    .best_rank  (best_rank_next),
    .sub_done   (sub_idx_next >= n),
    .sub_first  (sub_first_next),
    .sub_last   (sub_last_next),
    .found      (res_found),
    .position   (res_pos),
    .rank       (res_rank),
    .score      (res_score)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (process && in_last) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (process && in_last) begin
      m_tdata <= {4'b0000, ovf | !take, res_score, res_rank, res_pos, res_found};
    end
  end

  // checks
  a_not_found_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[0] |-> m_tdata[42:1] == '0)
    else $error("result fields not zero without a match");

  a_rank_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[18:17] != 2'd2)
    else $error("illegal quality rank");

  a_pos_bound: assert property (@(posedge clk) disable iff (rst)
    byte_pos <= CW'(TEXT_MAX))
    else $error("byte position beyond capacity");

  a_sub_bound: assert property (@(posedge clk) disable iff (rst)
    int'(sub_idx) <= QLEN_MAX)
    else $error("subsequence index beyond query");

  a_run_cleared: assert property (@(posedge clk) disable iff (rst)
    process && in_last |=> byte_pos == '0 && !best_found && sub_idx == '0 && !ovf)
    else $error("run state not cleared after final beat");

endmodule
